### hw/rtl/kl_bisection_refine_top_assert.svh
// Assertion macros shared by the refinement block.
`ifndef KL_BISECTION_REFINE_TOP_ASSERT_SVH
`define KL_BISECTION_REFINE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define KLBR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("klbr assertion failed");

// Next-cycle implication, disabled while reset is active.
`define KLBR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("klbr assertion failed");

`endif

### hw/rtl/klbr_pkg.sv
// Types and constants of the graph bisection refinement block.
package klbr_pkg;

	localparam int MAX_NODES   = 64;
	localparam int NODE_BITS   = 6;
	localparam int WEIGHT_BITS = 16;
	localparam int HALF_NODES  = MAX_NODES / 2;
	localparam int EDGE_DEPTH  = MAX_NODES * MAX_NODES;
	localparam int EDGE_BITS   = 2 * NODE_BITS;

	localparam logic [1:0] KIND_LOAD_EDGE = 2'd0;
	localparam logic [1:0] KIND_SET_SIDE  = 2'd1;
	localparam logic [1:0] KIND_RUN       = 2'd2;

	localparam logic CFG_NODE_COUNT = 1'b0;
	localparam logic CFG_MAX_PASSES = 1'b1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  node_a;
		logic [5:0]  node_b;
		logic [15:0] weight;
		logic        side;
	} item_t;

	typedef struct packed {
		logic [5:0] node_index;
		logic       final_side;
		logic       pass_limit_hit;
		logic       last;
	} result_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PASS_CHECK,
		ST_PASS_INIT,
		ST_DIFF,
		ST_DIFF_WAIT,
		ST_FETCH_A,
		ST_SWEEP,
		ST_SWEEP_WAIT,
		ST_ROUND_END,
		ST_FINISH,
		ST_APPLY,
		ST_OUTPUT
	} state_t;

endpackage

### hw/rtl/kl_bisection_refine_top.sv
// Top level of the Kernighan-Lin bisection refinement block.
//
//  channel   handshake                 word
//  item      start / busy              klbr_pkg::item_t
//  result    strobe (no back-pressure) klbr_pkg::result_t
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// After reset the weight store is cleared while busy is high.
// Edge and side items can follow back to back.
// A run holds busy high: each pass sweeps node pairs in rounds through the single read port
// of the weight store, then applies the chosen swaps.
// Then n results follow, one per cycle; the receiver cannot stall them.
// Configuration writes are taken whenever busy is low.
`include "kl_bisection_refine_top_assert.svh"

module kl_bisection_refine_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  klbr_pkg::item_t   item,
	output logic              busy,
	output logic              strobe,
	output klbr_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data
);

	klbr_pkg::state_t state_q, state_d;

	logic [11:0] clr_q;
	logic [6:0]  node_count_q, n_q;
	logic [7:0]  max_passes_q, pass_q;
	logic        hit_q;
	logic [5:0]  nm1;
	logic [63:0] side_q, lock_q, mask;
	logic [5:0]  row_q, col_q, out_q;
	logic        accept;

	logic [15:0] wmem [klbr_pkg::EDGE_DEPTH];
	logic [15:0] w_rd_q;
	logic [11:0] w_raddr;
	logic signed [23:0] dmem [klbr_pkg::MAX_NODES];
	logic signed [23:0] d_rd_q;
	logic [5:0]  d_raddr;

	logic        vld_s1, diff_s1, lastc_s1;
	logic [5:0]  row_s1, col_s1;

	logic signed [23:0] acc_q, acc_sum, da_q;
	logic signed [25:0] gain, top_q;
	logic        any_q, elig;
	logic [5:0]  ta_q, tb_q;
	logic [5:0]  rounds_q, found_q, rounds_c;
	logic [6:0]  cnt0, cnt1;
	logic signed [31:0] sum_q, best_q, new_sum;
	logic [4:0]  bk_q, k_q;
	logic [11:0] swap_q [klbr_pkg::HALF_NODES];

	assign accept    = start && !busy;
	assign cfg_ready = !busy;
	assign nm1       = 6'(n_q - 7'd1);

	always_comb begin
		for (int i = 0; i < klbr_pkg::MAX_NODES; i++) begin
			mask[i] = (7'(i) < n_q);
		end
		cnt0     = 7'($countones(~side_q & mask));
		cnt1     = 7'($countones(side_q & mask));
		rounds_c = (cnt0 < cnt1) ? 6'(cnt0) : 6'(cnt1);
	end

	// Read addresses: the weight and difference stores are swept by row and column.
	always_comb begin
		w_raddr = {row_q, col_q};
		d_raddr = (state_q == klbr_pkg::ST_FETCH_A) ? row_q : col_q;
	end

	always_ff @(posedge clk) begin
		if (state_q == klbr_pkg::ST_CLEAR) begin
			wmem[clr_q] <= '0;
		end else if (accept && item.kind == klbr_pkg::KIND_LOAD_EDGE) begin
			wmem[{item.node_a, item.node_b}] <= item.weight;
		end
		w_rd_q <= wmem[w_raddr];
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && diff_s1 && lastc_s1) begin
			dmem[row_s1] <= acc_sum;
		end
		d_rd_q <= dmem[d_raddr];
	end

	always_comb begin
		acc_sum = acc_q;
		if (!lock_q[row_s1] && !lock_q[col_s1]) begin
			if (side_q[row_s1] == side_q[col_s1]) begin
				acc_sum = acc_q - $signed({8'b0, w_rd_q});
			end else begin
				acc_sum = acc_q + $signed({8'b0, w_rd_q});
			end
		end
		gain = $signed({{2{da_q[23]}}, da_q}) + $signed({{2{d_rd_q[23]}}, d_rd_q})
			- $signed({9'b0, w_rd_q, 1'b0});
		elig = !lock_q[row_s1] && !side_q[row_s1] && !lock_q[col_s1] && side_q[col_s1];
		new_sum = sum_q + 32'(top_q);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			klbr_pkg::ST_CLEAR: begin
				if (clr_q == 12'hFFF) state_d = klbr_pkg::ST_IDLE;
			end
			klbr_pkg::ST_IDLE: begin
				if (accept && item.kind == klbr_pkg::KIND_RUN) state_d = klbr_pkg::ST_PASS_CHECK;
			end
			klbr_pkg::ST_PASS_CHECK: begin
				state_d = (pass_q == max_passes_q) ? klbr_pkg::ST_OUTPUT : klbr_pkg::ST_PASS_INIT;
			end
			klbr_pkg::ST_PASS_INIT: begin
				state_d = (rounds_c == '0) ? klbr_pkg::ST_OUTPUT : klbr_pkg::ST_DIFF;
			end
			klbr_pkg::ST_DIFF: begin
				if (col_q == nm1 && row_q == nm1) state_d = klbr_pkg::ST_DIFF_WAIT;
			end
			klbr_pkg::ST_DIFF_WAIT: state_d = klbr_pkg::ST_FETCH_A;
			klbr_pkg::ST_FETCH_A:   state_d = klbr_pkg::ST_SWEEP;
			klbr_pkg::ST_SWEEP: begin
				if (col_q == nm1) begin
					state_d = (row_q == nm1) ? klbr_pkg::ST_SWEEP_WAIT : klbr_pkg::ST_FETCH_A;
				end
			end
			klbr_pkg::ST_SWEEP_WAIT: state_d = klbr_pkg::ST_ROUND_END;
			klbr_pkg::ST_ROUND_END: begin
				if (!any_q || found_q + 6'd1 == rounds_q) state_d = klbr_pkg::ST_FINISH;
				else state_d = klbr_pkg::ST_DIFF;
			end
			klbr_pkg::ST_FINISH: begin
				state_d = (found_q == '0 || best_q <= 0) ? klbr_pkg::ST_OUTPUT : klbr_pkg::ST_APPLY;
			end
			klbr_pkg::ST_APPLY: begin
				if (k_q == bk_q) state_d = klbr_pkg::ST_PASS_CHECK;
			end
			klbr_pkg::ST_OUTPUT: begin
				if (n_q == '0 || out_q == nm1) state_d = klbr_pkg::ST_IDLE;
			end
			default: state_d = klbr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy   = (state_q != klbr_pkg::ST_IDLE);
		strobe = (state_q == klbr_pkg::ST_OUTPUT) && (n_q != '0);
		result.node_index     = out_q;
		result.final_side     = side_q[out_q];
		result.pass_limit_hit = hit_q;
		result.last           = (out_q == nm1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= klbr_pkg::ST_CLEAR;
			clr_q        <= '0;
			node_count_q <= 7'd64;
			max_passes_q <= 8'd255;
			side_q       <= '0;
			lock_q       <= '0;
			vld_s1       <= 1'b0;
			pass_q       <= '0;
			hit_q        <= 1'b0;
			n_q          <= '0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == klbr_pkg::ST_DIFF) || (state_q == klbr_pkg::ST_SWEEP);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == klbr_pkg::CFG_NODE_COUNT) node_count_q <= cfg_data[6:0];
				else max_passes_q <= cfg_data;
			end
			if (state_q == klbr_pkg::ST_CLEAR) clr_q <= clr_q + 12'd1;
			if (accept && item.kind == klbr_pkg::KIND_SET_SIDE) side_q[item.node_a] <= item.side;
			if (accept && item.kind == klbr_pkg::KIND_RUN) begin
				n_q    <= (node_count_q > 7'd64) ? 7'd64 : node_count_q;
				pass_q <= '0;
				hit_q  <= 1'b0;
			end
			if (state_q == klbr_pkg::ST_PASS_CHECK && pass_q == max_passes_q) hit_q <= 1'b1;
			if (state_q == klbr_pkg::ST_PASS_INIT || state_q == klbr_pkg::ST_FINISH) lock_q <= '0;
			if (state_q == klbr_pkg::ST_ROUND_END && any_q) begin
				lock_q <= lock_q | (64'd1 << ta_q) | (64'd1 << tb_q);
			end
			if (state_q == klbr_pkg::ST_APPLY) begin
				side_q <= side_q ^ (64'd1 << swap_q[k_q][11:6]) ^ (64'd1 << swap_q[k_q][5:0]);
				if (k_q == bk_q) pass_q <= pass_q + 8'd1;
			end
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		diff_s1  <= (state_q == klbr_pkg::ST_DIFF);
		row_s1   <= row_q;
		col_s1   <= col_q;
		lastc_s1 <= (col_q == nm1);
		out_q    <= (state_q == klbr_pkg::ST_OUTPUT) ? out_q + 6'd1 : '0;

		if (vld_s1 && diff_s1) begin
			acc_q <= lastc_s1 ? '0 : acc_sum;
		end
		if (vld_s1 && !diff_s1 && elig && (!any_q || gain > top_q)) begin
			any_q <= 1'b1;
			top_q <= gain;
			ta_q  <= row_s1;
			tb_q  <= col_s1;
		end

		unique case (state_q)
			klbr_pkg::ST_PASS_INIT: begin
				rounds_q <= rounds_c;
				found_q  <= '0;
				sum_q    <= '0;
				best_q   <= '0;
				row_q    <= '0;
				col_q    <= '0;
				acc_q    <= '0;
			end
			klbr_pkg::ST_DIFF, klbr_pkg::ST_SWEEP: begin
				if (state_q == klbr_pkg::ST_SWEEP && col_q == '0) da_q <= d_rd_q;
				if (col_q == nm1) begin
					col_q <= '0;
					row_q <= row_q + 6'd1;
				end else begin
					col_q <= col_q + 6'd1;
				end
			end
			klbr_pkg::ST_DIFF_WAIT: begin
				row_q <= '0;
				col_q <= '0;
				any_q <= 1'b0;
			end
			klbr_pkg::ST_ROUND_END: begin
				row_q <= '0;
				col_q <= '0;
				acc_q <= '0;
				if (any_q) begin
					swap_q[found_q[4:0]] <= {ta_q, tb_q};
					sum_q   <= new_sum;
					found_q <= found_q + 6'd1;
					if (found_q == '0 || new_sum > best_q) begin
						best_q <= new_sum;
						bk_q   <= found_q[4:0];
					end
				end
			end
			klbr_pkg::ST_FINISH: k_q <= '0;
			klbr_pkg::ST_APPLY:  k_q <= k_q + 5'd1;
			default: ;
		endcase
	end

	`KLBR_ASSERT_IMP(a_strobe_busy, clk, arst_n, strobe, busy)
	`KLBR_ASSERT_NXT(a_run_busy, clk, arst_n, accept && item.kind == klbr_pkg::KIND_RUN, busy)
	`KLBR_ASSERT_NXT(a_last_ends, clk, arst_n, strobe && result.last, !strobe)
	`KLBR_ASSERT_IMP(a_no_accept_clear, clk, arst_n, state_q == klbr_pkg::ST_CLEAR, !accept)

endmodule

### tb/sv/tb.sv
// Testbench for the Kernighan-Lin bisection refinement block, with a built-in partition predictor.
module tb;

	localparam int         ITEM_W       = $bits(klbr_pkg::item_t);
	localparam logic [1:0] KIND_UNKNOWN = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	klbr_pkg::item_t   item = '0;
	logic              busy;
	logic              strobe;
	klbr_pkg::result_t result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic              cfg_index = 1'b0;
	logic [7:0]        cfg_data = '0;

	kl_bisection_refine_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item), .busy(busy),
		.strobe(strobe), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor state.
	logic [15:0] pr_weight [klbr_pkg::EDGE_DEPTH];
	logic        pr_side [klbr_pkg::MAX_NODES];
	logic        pr_locked [klbr_pkg::MAX_NODES];
	longint      pr_diff [klbr_pkg::MAX_NODES];
	int unsigned pr_node_count = 64;
	int unsigned pr_max_passes = 255;

	klbr_pkg::result_t expected_sides [$];
	int      errors = 0;
	int      sent_items = 0;
	int      idle_pct = 0;

	// The block comes out of reset with a cleared weight store and every node on side 0.
	function automatic void clear_model();
		for (int i = 0; i < klbr_pkg::EDGE_DEPTH; i++)
			pr_weight[i] = '0;
		for (int i = 0; i < klbr_pkg::MAX_NODES; i++) begin
			pr_side[i] = 1'b0;
			pr_locked[i] = 1'b0;
			pr_diff[i] = 0;
		end
	endfunction

	function automatic void compute_diffs(int n);
		longint d;
		for (int u = 0; u < n; u++) begin
			d = 0;
			if (!pr_locked[u]) begin
				for (int v = 0; v < n; v++) begin
					if (pr_locked[v])
						continue;
					if (pr_side[v] == pr_side[u])
						d -= longint'(pr_weight[u * klbr_pkg::MAX_NODES + v]);
					else
						d += longint'(pr_weight[u * klbr_pkg::MAX_NODES + v]);
				end
			end
			pr_diff[u] = d;
		end
	endfunction

	// One refinement pass; returns 1 if any pair was swapped.
	function automatic bit refine_pass(int n);
		int     cnt0, cnt1, rounds, found, best_k, ta, tb;
		longint sum, best, top, g;
		bit     any, have_best;
		longint gains [klbr_pkg::HALF_NODES];
		int     pair_a [klbr_pkg::HALF_NODES];
		int     pair_b [klbr_pkg::HALF_NODES];
		cnt0 = 0; cnt1 = 0; found = 0; best_k = 0; sum = 0; best = 0; have_best = 0;
		for (int u = 0; u < n; u++) begin
			pr_locked[u] = 1'b0;
			if (pr_side[u]) cnt1++; else cnt0++;
		end
		rounds = (cnt0 < cnt1) ? cnt0 : cnt1;
		if (rounds > klbr_pkg::HALF_NODES)
			rounds = klbr_pkg::HALF_NODES;
		compute_diffs(n);
		for (int r = 0; r < rounds; r++) begin
			any = 0; top = 0; ta = 0; tb = 0;
			for (int a = 0; a < n; a++) begin
				if (pr_locked[a] || pr_side[a])
					continue;
				for (int b = 0; b < n; b++) begin
					if (pr_locked[b] || !pr_side[b])
						continue;
					g = pr_diff[a] + pr_diff[b]
						- 2 * longint'(pr_weight[a * klbr_pkg::MAX_NODES + b]);
					if (!any || g > top) begin
						any = 1; top = g; ta = a; tb = b;
					end
				end
			end
			if (!any)
				break;
			gains[found] = top;
			pair_a[found] = ta;
			pair_b[found] = tb;
			found++;
			pr_locked[ta] = 1'b1;
			pr_locked[tb] = 1'b1;
			compute_diffs(n);
		end
		for (int k = 0; k < found; k++) begin
			sum += gains[k];
			if (!have_best || sum > best) begin
				have_best = 1; best = sum; best_k = k;
			end
		end
		for (int u = 0; u < n; u++)
			pr_locked[u] = 1'b0;
		if (!have_best || best <= 0)
			return 0;
		for (int k = 0; k <= best_k; k++) begin
			pr_side[pair_a[k]] = ~pr_side[pair_a[k]];
			pr_side[pair_b[k]] = ~pr_side[pair_b[k]];
		end
		return 1;
	endfunction

	function automatic void predict_item(klbr_pkg::item_t it);
		int                n;
		int unsigned       passes;
		bit                hit;
		klbr_pkg::result_t r;
		case (it.kind)
			klbr_pkg::KIND_LOAD_EDGE:
				pr_weight[it.node_a * klbr_pkg::MAX_NODES + it.node_b] = it.weight;
			klbr_pkg::KIND_SET_SIDE:  pr_side[it.node_a] = it.side;
			klbr_pkg::KIND_RUN: begin
				n = (pr_node_count > klbr_pkg::MAX_NODES) ? klbr_pkg::MAX_NODES : pr_node_count;
				passes = 0;
				hit = 0;
				forever begin
					if (passes == pr_max_passes) begin
						hit = 1;
						break;
					end
					if (!refine_pass(n))
						break;
					passes = (passes + 1) & 8'hFF;
				end
				for (int i = 0; i < n; i++) begin
					r.node_index = 6'(i);
					r.final_side = pr_side[i];
					r.pass_limit_hit = hit;
					r.last = (i + 1 == n);
					expected_sides = {expected_sides, r};
				end
			end
			default: ;
		endcase
	endfunction

	// Results can't be held off, so each strobe is checked at the falling edge.
	always @(negedge clk) begin
		klbr_pkg::result_t want;
		if (arst_n && strobe) begin
			if (expected_sides.size() == 0) begin
				$display("%0t: unexpected result, expected nothing, actual %p", $time, result);
				errors++;
			end else begin
				want = expected_sides.pop_front();
				if (result !== want) begin
					$display("%0t: result mismatch, expected %p, actual %p", $time, want, result);
					errors++;
				end
			end
		end
	end

	task automatic send_item(klbr_pkg::item_t it);
		start <= 1'b1;
		item <= it;
		do @(negedge clk); while (busy !== 1'b0);
		@(posedge clk);
		predict_item(it);
		sent_items++;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic send_edge(int a, int b, int w);
		klbr_pkg::item_t it;
		it = '0;
		it.kind = klbr_pkg::KIND_LOAD_EDGE;
		it.node_a = 6'(a);
		it.node_b = 6'(b);
		it.weight = 16'(w);
		it.side = 1'($urandom_range(1));
		send_item(it);
	endtask

	task automatic send_side(int a, bit s);
		klbr_pkg::item_t it;
		it = ITEM_W'($urandom);
		it.kind = klbr_pkg::KIND_SET_SIDE;
		it.node_a = 6'(a);
		it.side = s;
		send_item(it);
	endtask

	task automatic send_run();
		klbr_pkg::item_t it;
		it = ITEM_W'($urandom);
		it.kind = klbr_pkg::KIND_RUN;
		send_item(it);
	endtask

	// Waits until every expected result is out and the block is idle again.
	task automatic wait_drained();
		start <= 1'b0;
		while (expected_sides.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		do @(negedge clk); while (busy !== 1'b0);
		@(posedge clk);
	endtask

	task automatic write_reg(logic idx, int value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 8'(value);
		do @(negedge clk); while (cfg_ready !== 1'b1);
		@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == klbr_pkg::CFG_NODE_COUNT)
			pr_node_count = value & 8'h7F;
		else
			pr_max_passes = value & 8'hFF;
	endtask

	task automatic test_small_graphs();
		write_reg(klbr_pkg::CFG_NODE_COUNT, 2);
		write_reg(klbr_pkg::CFG_MAX_PASSES, 255);
		send_side(1, 1'b1);
		send_edge(0, 1, 16'hFFFF);
		send_edge(1, 0, 1);
		send_edge(0, 0, 5);
		send_run();
		write_reg(klbr_pkg::CFG_NODE_COUNT, 4);
		send_side(2, 1'b0);
		send_side(3, 1'b1);
		send_edge(0, 3, 100);
		send_edge(3, 0, 100);
		send_edge(1, 2, 100);
		send_edge(2, 1, 100);
		send_run();
	endtask

	task automatic test_corner_counts();
		klbr_pkg::item_t junk;
		junk = ITEM_W'($urandom);
		junk.kind = KIND_UNKNOWN;
		send_item(junk);
		send_edge(63, 63, 16'hAAAA);
		send_edge(62, 61, 16'h5555);
		write_reg(klbr_pkg::CFG_NODE_COUNT, 1);
		send_run();
		write_reg(klbr_pkg::CFG_NODE_COUNT, 0);
		send_run();
		write_reg(klbr_pkg::CFG_NODE_COUNT, 127);
		write_reg(klbr_pkg::CFG_MAX_PASSES, 0);
		send_run();
	endtask

	task automatic test_full_size();
		write_reg(klbr_pkg::CFG_NODE_COUNT, 64);
		write_reg(klbr_pkg::CFG_MAX_PASSES, 1);
		send_side(62, 1'b1);
		send_edge(62, 5, 300);
		send_edge(0, 62, 900);
		send_run();
	endtask

	task automatic random_graph();
		int n;
		int mp;
		klbr_pkg::item_t junk;
		n = ($urandom_range(7) == 0) ? 16 : $urandom_range(2, 8);
		mp = (n <= 4 && $urandom_range(3) == 0) ? 255 : $urandom_range(1, 6);
		write_reg(klbr_pkg::CFG_NODE_COUNT, n);
		write_reg(klbr_pkg::CFG_MAX_PASSES, mp);
		for (int i = 0; i < n; i++)
			send_side(i, 1'($urandom_range(1)));
		repeat ($urandom_range(n, 3 * n)) begin
			case ($urandom_range(9))
				0: send_edge($urandom_range(63), $urandom_range(63), $urandom);
				1: send_edge($urandom_range(n - 1), $urandom_range(n - 1), 0);
				2: send_edge($urandom_range(n - 1), $urandom_range(n - 1), 16'hFFFF);
				3: begin
					junk = ITEM_W'($urandom);
					junk.kind = KIND_UNKNOWN;
					send_item(junk);
				end
				4: send_side($urandom_range(63), 1'($urandom_range(1)));
				default: send_edge($urandom_range(n - 1), $urandom_range(n - 1),
					$urandom_range(200));
			endcase
		end
		send_run();
	endtask

	task automatic test_random(int goal);
		int stop_at;
		stop_at = sent_items + goal;
		while (sent_items < stop_at)
			random_graph();
	endtask

	initial begin
		clear_model();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_small_graphs();
		test_corner_counts();
		test_full_size();
		idle_pct = 22;
		test_random(95);
		idle_pct = 72;
		test_random(95);
		idle_pct = 0;
		test_random(95);
		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_sides.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#40000000;
		$display("FAIL");
		$finish;
	end

endmodule
